// ===== hw/rtl/thp_pkg.sv =====
// Shared types, codes and constants of the heightfield stream parser.
package thp_pkg;

    // Parser phases, one-hot coded.
    typedef enum logic [7:0] {
        PH_SIG    = 8'b0000_0001,
        PH_MARKER = 8'b0000_0010,
        PH_VALUE  = 8'b0000_0100,
        PH_SKIP   = 8'b0000_1000,
        PH_ALTHDR = 8'b0001_0000,
        PH_ELEV   = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } t_phase;

    // Result word kinds.
    typedef enum logic [1:0] {
        KIND_ELEV    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_BAD_SIG = 2'd2,
        KIND_TRUNC   = 2'd3
    } t_kind;

    // File signature, one character per byte position.
    parameter logic [7:0] SIG_TEXT [16] = '{
        "T", "E", "R", "R", "A", "G", "E", "N",
        "T", "E", "R", "R", "A", "I", "N", " "
    };

    // Segment markers, first byte in the top bits.
    parameter logic [31:0] MK_SIZE = "SIZE";
    parameter logic [31:0] MK_XPTS = "XPTS";
    parameter logic [31:0] MK_YPTS = "YPTS";
    parameter logic [31:0] MK_SCAL = "SCAL";
    parameter logic [31:0] MK_CRAD = "CRAD";
    parameter logic [31:0] MK_CRVM = "CRVM";
    parameter logic [31:0] MK_ALTW = "ALTW";

    // Bytes left to skip after a marker, minus one.
    parameter logic [3:0] SKIP_SCAL = 4'd11;
    parameter logic [3:0] SKIP_CURV = 4'd3;

    // Complete parser state.
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  cnt;
        logic [31:0] marker;
        logic        sig_bad;
        logic [7:0]  low;
        logic [16:0] rows;
        logic [16:0] cols;
        logic [15:0] row_cnt;
        logic [15:0] col_cnt;
        logic [15:0] scale;
        logic [15:0] base;
    } t_state;

    parameter t_state STATE_RESET = '{
        phase:   PH_SIG,
        cnt:     4'd0,
        marker:  32'd0,
        sig_bad: 1'b0,
        low:     8'd0,
        rows:    17'd0,
        cols:    17'd0,
        row_cnt: 16'd0,
        col_cnt: 16'd0,
        scale:   16'd0,
        base:    16'd0
    };

    // One result word.
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] elevation;
        logic [15:0]        row_index;
        logic [15:0]        col_index;
        logic               last;
        logic [16:0]        map_cols;
        logic [16:0]        map_rows;
        logic [15:0]        height_scale;
        logic [15:0]        base_height;
    } t_result;

endpackage

// ===== hw/rtl/thp_if.sv =====
// Handshake interfaces for the byte input and the result output channels.
interface thp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface thp_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [15:0] elevation;
    logic [15:0]        row_index;
    logic [15:0]        col_index;
    logic               last_elevation;
    logic [16:0]        map_cols;
    logic [16:0]        map_rows;
    logic [15:0]        height_scale;
    logic [15:0]        base_height;

    modport source (
        output valid, output result_kind, output elevation, output row_index,
        output col_index, output last_elevation, output map_cols, output map_rows,
        output height_scale, output base_height, input ready
    );
    modport sink (
        input valid, input result_kind, input elevation, input row_index,
        input col_index, input last_elevation, input map_cols, input map_rows,
        input height_scale, input base_height, output ready
    );
endinterface

// ===== hw/rtl/terrain_heightfield_parser_core.sv =====
// Top level of the heightfield stream parser: input register, parse step, result register.
//
// Usage:
//   i_byte carries one file byte per word together with an end-of-data flag
//   that marks the last byte of a buffer. o_res carries result words: one
//   per completed elevation (with row, column and a last flag), or a status
//   word for an empty map, a bad signature or a truncated stream. Every
//   result also shows the map size, scale word and base word in effect.
//   Throughput: one byte per clock. The parse state is updated once per byte
//   by the step logic between the input register and the result register.
//   A result passes from the step logic into the result register, which drives o_res.
//   Bytes that make no result never wait on the output side. When a result
//   is still held because the receiver stalls, the next byte that makes a
//   result waits in the input register and i_byte.ready drops until the
//   held result is taken.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to the signature check. After a byte flagged end of data the
//   parser returns to the same state on its own.
module terrain_heightfield_parser_core (
    input logic        i_clk,
    input logic        i_rst_n,
    thp_byte_if.sink   i_byte,
    thp_res_if.source  o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eod;
    thp_pkg::t_state  r_state;
    logic             r_out_valid;
    thp_pkg::t_result r_out;

    thp_pkg::t_state  n_state;
    thp_pkg::t_result step_result;
    logic             step_emit;
    logic             proc;

    // Parse step on the registered byte.
    thp_step u_step (
        .i_state       (r_state),
        .i_data_byte   (r_in_byte),
        .i_end_of_data (r_in_eod),
        .o_state       (n_state),
        .o_emit        (step_emit),
        .o_result      (step_result)
    );

    // A byte advances unless it makes a result while the output is still held.
    assign proc         = r_in_valid && (!step_emit || !r_out_valid || o_res.ready);
    assign i_byte.ready = !r_in_valid || proc;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eod  <= i_byte.end_of_data;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thp_pkg::STATE_RESET;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && step_emit) begin
            r_out <= step_result;
        end
    end

    // Output port drive.
    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_out.kind;
    assign o_res.elevation      = r_out.elevation;
    assign o_res.row_index      = r_out.row_index;
    assign o_res.col_index      = r_out.col_index;
    assign o_res.last_elevation = r_out.last;
    assign o_res.map_cols       = r_out.map_cols;
    assign o_res.map_rows       = r_out.map_rows;
    assign o_res.height_scale   = r_out.height_scale;
    assign o_res.base_height    = r_out.base_height;

    // A held result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready && proc) |-> !step_emit)
        else $error("result register overwritten while stalled");

    // An end-of-data byte always returns the parser to the signature check.
    a_eod_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_eod) |=> (r_state.phase == thp_pkg::PH_SIG && r_state.cnt == 4'd0))
        else $error("parser not reset after end of data");

    // Elevation words come only from the elevation phase.
    a_elev_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && step_emit && step_result.kind == thp_pkg::KIND_ELEV)
            |-> (r_state.phase == thp_pkg::PH_ELEV))
        else $error("elevation emitted outside elevation phase");

    // The last flag belongs to elevation words only.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.kind == thp_pkg::KIND_ELEV))
        else $error("last flag on a status word");

endmodule

// ===== hw/rtl/thp_step.sv =====
// Next-state and result logic of the parser for one input byte.
module thp_step (
    input  thp_pkg::t_state  i_state,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_data,
    output thp_pkg::t_state  o_state,
    output logic             o_emit,
    output thp_pkg::t_result o_result
);

    thp_pkg::t_state  upd;
    thp_pkg::t_kind   kind;
    logic             emit;
    logic             last;
    logic             active;
    logic [15:0]      word;
    logic [16:0]      row_next;
    logic [16:0]      col_next;
    logic [31:0]      marker_new;

    // Shared byte assembly and counter increments.
    assign word       = {i_data_byte, i_state.low};
    assign row_next   = {1'b0, i_state.row_cnt} + 17'd1;
    assign col_next   = {1'b0, i_state.col_cnt} + 17'd1;
    assign marker_new = {i_state.marker[23:0], i_data_byte};
    assign active     = (i_state.phase != thp_pkg::PH_DONE) &&
                        (i_state.phase != thp_pkg::PH_ERROR);

    // Per-phase byte handling.
    always_comb begin
        upd  = i_state;
        emit = 1'b0;
        kind = thp_pkg::KIND_ELEV;
        last = 1'b0;
        unique case (i_state.phase)
            thp_pkg::PH_SIG: begin
                if (i_data_byte != thp_pkg::SIG_TEXT[i_state.cnt]) begin
                    upd.sig_bad = 1'b1;
                end
                if (i_state.cnt == 4'd15) begin
                    upd.cnt = 4'd0;
                    if (upd.sig_bad) begin
                        upd.phase = thp_pkg::PH_ERROR;
                        emit      = 1'b1;
                        kind      = thp_pkg::KIND_BAD_SIG;
                    end else begin
                        upd.phase = thp_pkg::PH_MARKER;
                    end
                end else begin
                    upd.cnt = i_state.cnt + 4'd1;
                end
            end
            thp_pkg::PH_MARKER: begin
                upd.marker = marker_new;
                if (i_state.cnt >= 4'd3) begin
                    upd.cnt = 4'd0;
                    if (marker_new == thp_pkg::MK_SIZE || marker_new == thp_pkg::MK_XPTS ||
                        marker_new == thp_pkg::MK_YPTS) begin
                        upd.phase = thp_pkg::PH_VALUE;
                    end else if (marker_new == thp_pkg::MK_SCAL) begin
                        upd.phase = thp_pkg::PH_SKIP;
                        upd.cnt   = thp_pkg::SKIP_SCAL;
                    end else if (marker_new == thp_pkg::MK_CRAD ||
                                 marker_new == thp_pkg::MK_CRVM) begin
                        upd.phase = thp_pkg::PH_SKIP;
                        upd.cnt   = thp_pkg::SKIP_CURV;
                    end else if (marker_new == thp_pkg::MK_ALTW) begin
                        upd.phase = thp_pkg::PH_ALTHDR;
                    end
                end else begin
                    upd.cnt = i_state.cnt + 4'd1;
                end
            end
            thp_pkg::PH_VALUE: begin
                if (i_state.cnt == 4'd0) begin
                    upd.low = i_data_byte;
                end else if (i_state.cnt == 4'd1) begin
                    if (i_state.marker == thp_pkg::MK_SIZE) begin
                        upd.rows = {1'b0, word} + 17'd1;
                        upd.cols = {1'b0, word} + 17'd1;
                    end else if (i_state.marker == thp_pkg::MK_XPTS) begin
                        upd.cols = {1'b0, word};
                    end else begin
                        upd.rows = {1'b0, word};
                    end
                end
                if (i_state.cnt >= 4'd3) begin
                    upd.cnt   = 4'd0;
                    upd.phase = thp_pkg::PH_MARKER;
                end else begin
                    upd.cnt = i_state.cnt + 4'd1;
                end
            end
            thp_pkg::PH_SKIP: begin
                if (i_state.cnt == 4'd0) begin
                    upd.phase = thp_pkg::PH_MARKER;
                end else begin
                    upd.cnt = i_state.cnt - 4'd1;
                end
            end
            thp_pkg::PH_ALTHDR: begin
                if (i_state.cnt == 4'd0 || i_state.cnt == 4'd2) begin
                    upd.low = i_data_byte;
                    upd.cnt = i_state.cnt + 4'd1;
                end else if (i_state.cnt == 4'd1) begin
                    upd.scale = word;
                    upd.cnt   = i_state.cnt + 4'd1;
                end else begin
                    upd.base = word;
                    upd.cnt  = 4'd0;
                    if (i_state.rows == 17'd0 || i_state.cols == 17'd0) begin
                        upd.phase = thp_pkg::PH_DONE;
                        emit      = 1'b1;
                        kind      = thp_pkg::KIND_EMPTY;
                    end else begin
                        upd.phase   = thp_pkg::PH_ELEV;
                        upd.row_cnt = 16'd0;
                        upd.col_cnt = 16'd0;
                    end
                end
            end
            thp_pkg::PH_ELEV: begin
                if (i_state.cnt == 4'd0) begin
                    upd.low = i_data_byte;
                    upd.cnt = 4'd1;
                end else begin
                    upd.cnt = 4'd0;
                    emit    = 1'b1;
                    last    = (row_next == i_state.rows) && (col_next == i_state.cols);
                    if (last) begin
                        upd.phase = thp_pkg::PH_DONE;
                    end else if (col_next >= i_state.cols) begin
                        upd.col_cnt = 16'd0;
                        upd.row_cnt = row_next[15:0];
                    end else begin
                        upd.col_cnt = col_next[15:0];
                    end
                end
            end
            default: begin
                // Done or error: bytes are dropped until end of data.
            end
        endcase
    end

    // End of data: flag truncation unless a final result was made, then reset.
    always_comb begin
        o_emit             = emit;
        o_result.kind      = kind;
        o_result.elevation = (kind == thp_pkg::KIND_ELEV) ? word : 16'sd0;
        o_result.row_index = (kind == thp_pkg::KIND_ELEV) ? i_state.row_cnt : 16'd0;
        o_result.col_index = (kind == thp_pkg::KIND_ELEV) ? i_state.col_cnt : 16'd0;
        o_result.last      = last;
        if (i_end_of_data && active && !(emit && (kind != thp_pkg::KIND_ELEV || last))) begin
            o_emit             = 1'b1;
            o_result.kind      = thp_pkg::KIND_TRUNC;
            o_result.elevation = 16'sd0;
            o_result.row_index = 16'd0;
            o_result.col_index = 16'd0;
            o_result.last      = 1'b0;
        end
        o_result.map_cols     = upd.cols;
        o_result.map_rows     = upd.rows;
        o_result.height_scale = upd.scale;
        o_result.base_height  = upd.base;
        o_state               = i_end_of_data ? thp_pkg::STATE_RESET : upd;
    end

endmodule

// ===== bench/terrain_heightfield_parser_core_test.sv =====
// Self-checking testbench for the heightfield stream parser core: directed files, then random ones.
`timescale 1ns / 1ps

module terrain_heightfield_parser_core_test;

    localparam int RANDOM_BYTES   = 1200;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 400;

    logic i_clk;
    logic i_rst_n;

    thp_byte_if byte_ch ();
    thp_res_if  res_ch ();

    terrain_heightfield_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch)
    );

    // Parser state as the bench tracks it, and the results it still owes.
    thp_pkg::t_state  parse_st;
    thp_pkg::t_result pending_results [$];
    logic [7:0]       file_bytes [$];

    int error_count;
    int results_seen;
    int bytes_sent;
    int sink_hold;
    int stall_cycles;
    bit src_idle_on;
    bit sink_idle_on;

    // 4 ns clock.
    always #2 i_clk = ~i_clk;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Advance the tracked parser by one byte and queue the word it produces, if any.
    task automatic parse_byte(input logic [7:0] b, input logic eod);
        thp_pkg::t_result r;
        bit               emit;
        logic             active;
        logic [15:0]      word;
        logic [16:0]      row_next;
        logic [16:0]      col_next;

        r        = '0;
        emit     = 1'b0;
        active   = (parse_st.phase != thp_pkg::PH_DONE) &&
                   (parse_st.phase != thp_pkg::PH_ERROR);
        word     = {b, parse_st.low};
        row_next = {1'b0, parse_st.row_cnt} + 17'd1;
        col_next = {1'b0, parse_st.col_cnt} + 17'd1;

        case (parse_st.phase)
            thp_pkg::PH_SIG: begin
                if (b != thp_pkg::SIG_TEXT[parse_st.cnt])
                    parse_st.sig_bad = 1'b1;
                if (parse_st.cnt == 4'd15) begin
                    parse_st.cnt = 4'd0;
                    if (parse_st.sig_bad) begin
                        parse_st.phase = thp_pkg::PH_ERROR;
                        r.kind         = thp_pkg::KIND_BAD_SIG;
                        emit           = 1'b1;
                    end else begin
                        parse_st.phase = thp_pkg::PH_MARKER;
                    end
                end else begin
                    parse_st.cnt = parse_st.cnt + 4'd1;
                end
            end
            thp_pkg::PH_MARKER: begin
                parse_st.marker = {parse_st.marker[23:0], b};
                if (parse_st.cnt == 4'd3) begin
                    parse_st.cnt = 4'd0;
                    if (parse_st.marker == thp_pkg::MK_SIZE ||
                        parse_st.marker == thp_pkg::MK_XPTS ||
                        parse_st.marker == thp_pkg::MK_YPTS) begin
                        parse_st.phase = thp_pkg::PH_VALUE;
                    end else if (parse_st.marker == thp_pkg::MK_SCAL) begin
                        parse_st.phase = thp_pkg::PH_SKIP;
                        parse_st.cnt   = thp_pkg::SKIP_SCAL;
                    end else if (parse_st.marker == thp_pkg::MK_CRAD ||
                                 parse_st.marker == thp_pkg::MK_CRVM) begin
                        parse_st.phase = thp_pkg::PH_SKIP;
                        parse_st.cnt   = thp_pkg::SKIP_CURV;
                    end else if (parse_st.marker == thp_pkg::MK_ALTW) begin
                        parse_st.phase = thp_pkg::PH_ALTHDR;
                    end
                end else begin
                    parse_st.cnt = parse_st.cnt + 4'd1;
                end
            end
            thp_pkg::PH_VALUE: begin
                // Low byte, high byte, then two bytes of padding.
                if (parse_st.cnt == 4'd0) begin
                    parse_st.low = b;
                end else if (parse_st.cnt == 4'd1) begin
                    if (parse_st.marker == thp_pkg::MK_SIZE) begin
                        parse_st.rows = {1'b0, word} + 17'd1;
                        parse_st.cols = {1'b0, word} + 17'd1;
                    end else if (parse_st.marker == thp_pkg::MK_XPTS) begin
                        parse_st.cols = {1'b0, word};
                    end else begin
                        parse_st.rows = {1'b0, word};
                    end
                end
                if (parse_st.cnt == 4'd3) begin
                    parse_st.cnt   = 4'd0;
                    parse_st.phase = thp_pkg::PH_MARKER;
                end else begin
                    parse_st.cnt = parse_st.cnt + 4'd1;
                end
            end
            thp_pkg::PH_SKIP: begin
                if (parse_st.cnt == 4'd0)
                    parse_st.phase = thp_pkg::PH_MARKER;
                else
                    parse_st.cnt = parse_st.cnt - 4'd1;
            end
            thp_pkg::PH_ALTHDR: begin
                if (parse_st.cnt == 4'd0 || parse_st.cnt == 4'd2) begin
                    parse_st.low = b;
                    parse_st.cnt = parse_st.cnt + 4'd1;
                end else if (parse_st.cnt == 4'd1) begin
                    parse_st.scale = word;
                    parse_st.cnt   = parse_st.cnt + 4'd1;
                end else begin
                    parse_st.base = word;
                    parse_st.cnt  = 4'd0;
                    if (parse_st.rows == 17'd0 || parse_st.cols == 17'd0) begin
                        parse_st.phase = thp_pkg::PH_DONE;
                        r.kind         = thp_pkg::KIND_EMPTY;
                        emit           = 1'b1;
                    end else begin
                        parse_st.phase   = thp_pkg::PH_ELEV;
                        parse_st.row_cnt = 16'd0;
                        parse_st.col_cnt = 16'd0;
                    end
                end
            end
            thp_pkg::PH_ELEV: begin
                if (parse_st.cnt == 4'd0) begin
                    parse_st.low = b;
                    parse_st.cnt = 4'd1;
                end else begin
                    parse_st.cnt = 4'd0;
                    r.kind       = thp_pkg::KIND_ELEV;
                    r.elevation  = word;
                    r.row_index  = parse_st.row_cnt;
                    r.col_index  = parse_st.col_cnt;
                    r.last       = (row_next == parse_st.rows) && (col_next == parse_st.cols);
                    emit         = 1'b1;
                    if (r.last) begin
                        parse_st.phase = thp_pkg::PH_DONE;
                    end else if (col_next >= parse_st.cols) begin
                        parse_st.col_cnt = 16'd0;
                        parse_st.row_cnt = parse_st.row_cnt + 16'd1;
                    end else begin
                        parse_st.col_cnt = parse_st.col_cnt + 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        // End of data cuts a live parse short, unless this byte already closed it.
        if (eod && active && !(emit && (r.kind != thp_pkg::KIND_ELEV || r.last))) begin
            r      = '0;
            r.kind = thp_pkg::KIND_TRUNC;
            emit   = 1'b1;
        end

        r.map_cols     = parse_st.cols;
        r.map_rows     = parse_st.rows;
        r.height_scale = parse_st.scale;
        r.base_height  = parse_st.base;
        if (emit)
            pending_results.push_back(r);
        if (eod)
            parse_st = thp_pkg::STATE_RESET;
    endtask

    // Compare one accepted result word with the oldest expected one.
    task automatic check_result();
        thp_pkg::t_result got;
        thp_pkg::t_result want;

        got.kind         = thp_pkg::t_kind'(res_ch.result_kind);
        got.elevation    = res_ch.elevation;
        got.row_index    = res_ch.row_index;
        got.col_index    = res_ch.col_index;
        got.last         = res_ch.last_elevation;
        got.map_cols     = res_ch.map_cols;
        got.map_rows     = res_ch.map_rows;
        got.height_scale = res_ch.height_scale;
        got.base_height  = res_ch.base_height;
        results_seen++;

        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d (kind %0d) arrived with none expected",
                                      results_seen, got.kind));
            return;
        end
        want = pending_results.pop_front();

        if (got.kind !== want.kind)
            report_mismatch($sformatf("result %0d kind: got %0d, expected %0d",
                                      results_seen, got.kind, want.kind));
        if (got.elevation !== want.elevation)
            report_mismatch($sformatf("result %0d elevation: got %0d, expected %0d",
                                      results_seen, got.elevation, want.elevation));
        if (got.row_index !== want.row_index)
            report_mismatch($sformatf("result %0d row: got %0d, expected %0d",
                                      results_seen, got.row_index, want.row_index));
        if (got.col_index !== want.col_index)
            report_mismatch($sformatf("result %0d column: got %0d, expected %0d",
                                      results_seen, got.col_index, want.col_index));
        if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last flag: got %0b, expected %0b",
                                      results_seen, got.last, want.last));
        if (got.map_cols !== want.map_cols)
            report_mismatch($sformatf("result %0d map columns: got %0d, expected %0d",
                                      results_seen, got.map_cols, want.map_cols));
        if (got.map_rows !== want.map_rows)
            report_mismatch($sformatf("result %0d map rows: got %0d, expected %0d",
                                      results_seen, got.map_rows, want.map_rows));
        if (got.height_scale !== want.height_scale)
            report_mismatch($sformatf("result %0d scale: got %h, expected %h",
                                      results_seen, got.height_scale, want.height_scale));
        if (got.base_height !== want.base_height)
            report_mismatch($sformatf("result %0d base: got %h, expected %h",
                                      results_seen, got.base_height, want.base_height));
    endtask

    // Result side: check every accepted word, then stall for a random number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            check_result();
            sink_hold = sink_idle_on ? $urandom_range(0, 7) : 0;
        end else if (sink_hold != 0) begin
            sink_hold--;
        end
        res_ch.ready <= (sink_hold == 0);
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one byte after a random gap and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;

        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_data <= eod;
        do @(posedge i_clk); while (!byte_ch.ready);
        parse_byte(b, eod);
        bytes_sent++;
    endtask

    // Send the assembled file; its last byte carries end of data.
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // File assembly helpers.
    task automatic put_text32(input logic [31:0] w);
        file_bytes.push_back(w[31:24]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endtask

    task automatic put_word16(input logic [15:0] w);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
    endtask

    // A negative position gives a clean signature; otherwise one bit is flipped there.
    task automatic put_signature(input int bad_pos);
        logic [7:0] b;

        for (int i = 0; i < 16; i++) begin
            b = thp_pkg::SIG_TEXT[i];
            if (i == bad_pos)
                b = b ^ (8'd1 << $urandom_range(0, 7));
            file_bytes.push_back(b);
        end
    endtask

    task automatic put_dims(input logic [31:0] mk, input logic [15:0] v);
        put_text32(mk);
        put_word16(v);
        put_word16(16'($urandom));
    endtask

    task automatic put_skipped(input logic [31:0] mk, input int n);
        put_text32(mk);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_elevations(input longint n);
        logic [15:0] e;

        for (longint i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0:       e = 16'h8000;
                1:       e = 16'h7FFF;
                2:       e = 16'h0000;
                3:       e = 16'hFFFF;
                default: e = 16'($urandom);
            endcase
            put_word16(e);
        end
    endtask

    // Bad signature, on the last byte and on the first one.
    task automatic test_bad_signature();
        put_signature(15);
        repeat (3) file_bytes.push_back(8'($urandom));
        send_file();
        put_signature(0);
        send_file();
    endtask

    // Square map from SIZE, every skipped segment, an unknown marker, extreme words.
    task automatic test_size_segments();
        put_signature(-1);
        put_dims(thp_pkg::MK_SIZE, 16'd1);
        put_skipped(thp_pkg::MK_SCAL, 12);
        put_skipped(thp_pkg::MK_CRAD, 4);
        put_skipped(thp_pkg::MK_CRVM, 4);
        put_text32("QZQZ");
        put_text32(thp_pkg::MK_ALTW);
        put_word16(16'hFFFF);
        put_word16(16'h8000);
        put_word16(16'h7FFF);
        put_word16(16'h8000);
        put_word16(16'h0000);
        put_word16(16'hFFFF);
        file_bytes.push_back(8'hA5);
        file_bytes.push_back(8'h5A);
        send_file();
    endtask

    // Separate column and row counts; end of data falls on the final elevation.
    task automatic test_xy_dims();
        put_signature(-1);
        put_dims(thp_pkg::MK_XPTS, 16'd3);
        put_dims(thp_pkg::MK_YPTS, 16'd2);
        put_text32(thp_pkg::MK_ALTW);
        put_word16(16'h0000);
        put_word16(16'h0000);
        put_elevations(6);
        send_file();
    endtask

    // No dimensions at all, then a zero column count.
    task automatic test_empty_map();
        put_signature(-1);
        put_text32(thp_pkg::MK_ALTW);
        put_word16(16'h1234);
        put_word16(16'hFEDC);
        send_file();
        put_signature(-1);
        put_dims(thp_pkg::MK_XPTS, 16'd0);
        put_dims(thp_pkg::MK_YPTS, 16'd4);
        put_text32(thp_pkg::MK_ALTW);
        put_word16(16'($urandom));
        put_word16(16'($urandom));
        file_bytes.push_back(8'($urandom));
        send_file();
    endtask

    // End of data at various points of a live parse.
    task automatic test_early_end();
        // Inside the signature, and on its last byte when it is good.
        put_signature(-1);
        repeat (11) void'(file_bytes.pop_back());
        send_file();
        put_signature(-1);
        send_file();
        // Largest square map, cut as a non-final elevation completes.
        put_signature(-1);
        put_dims(thp_pkg::MK_SIZE, 16'hFFFF);
        put_text32(thp_pkg::MK_ALTW);
        put_word16(16'h0001);
        put_word16(16'h0002);
        put_elevations(3);
        send_file();
        // Widest single row, cut between the two bytes of an elevation.
        put_signature(-1);
        put_dims(thp_pkg::MK_XPTS, 16'hFFFF);
        put_dims(thp_pkg::MK_YPTS, 16'd1);
        put_text32(thp_pkg::MK_ALTW);
        put_word16(16'($urandom));
        put_word16(16'($urandom));
        put_elevations(1);
        file_bytes.push_back(8'($urandom));
        send_file();
        // Half a marker.
        put_signature(-1);
        file_bytes.push_back("S");
        file_bytes.push_back("I");
        send_file();
    endtask

    // Random files: mostly well formed with random content, some broken or pure noise.
    task automatic test_random_files();
        int          stop_at;
        int          cut;
        longint      rows;
        longint      cols;
        longint      cells;
        logic [15:0] v;

        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
            end else begin
                put_signature(($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : -1);
                rows = 0;
                cols = 0;
                repeat ($urandom_range(1, 5)) begin
                    // Dimensions are mostly small; now and then a full 16-bit value.
                    v = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            put_dims(thp_pkg::MK_SIZE, v);
                            rows = longint'(v) + 1;
                            cols = longint'(v) + 1;
                        end
                        2, 3: begin
                            put_dims(thp_pkg::MK_XPTS, v);
                            cols = longint'(v);
                        end
                        4, 5: begin
                            put_dims(thp_pkg::MK_YPTS, v);
                            rows = longint'(v);
                        end
                        6:       put_skipped(thp_pkg::MK_SCAL, 12);
                        7:       put_skipped(thp_pkg::MK_CRAD, 4);
                        8:       put_skipped(thp_pkg::MK_CRVM, 4);
                        default: put_text32($urandom);
                    endcase
                end
                if ($urandom_range(0, 7) != 0) begin
                    put_text32(thp_pkg::MK_ALTW);
                    put_word16(16'($urandom));
                    put_word16(16'($urandom));
                    cells = rows * cols;
                    if (cells > 48)
                        cells = longint'($urandom_range(1, 6));
                    put_elevations(cells);
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
                end
                // Some files are cut short at a random point.
                if ($urandom_range(0, 4) == 0 && file_bytes.size() > 1) begin
                    cut = int'($urandom_range(1, file_bytes.size() - 1));
                    while (file_bytes.size() > cut)
                        void'(file_bytes.pop_back());
                end
            end
            send_file();
        end
    endtask

    // Reset, run the tests in turn, drain and report.
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'd0;
        byte_ch.end_of_data  = 1'b0;
        res_ch.ready         = 1'b0;
        parse_st             = thp_pkg::STATE_RESET;
        error_count          = 0;
        results_seen         = 0;
        bytes_sent           = 0;
        sink_hold            = 0;
        stall_cycles         = 0;
        src_idle_on          = 1'b1;
        sink_idle_on         = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_signature();
        test_size_segments();
        test_xy_dims();
        test_empty_map();
        test_early_end();
        test_random_files();

        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
